// ===== rtl/cop_pkg.sv =====
// Shared widths, types and tables of the circular orbit propagator.
package cop_pkg;

    localparam int PHASE_FRACTION_BITS = 48;
    localparam int ANGLE_BITS          = 16;

    localparam int TIME_W   = 63;
    localparam int RATE_W   = 32;
    localparam int STEP_W   = 32;
    localparam int RADIUS_W = 23;
    localparam int INCL_W   = 18;
    localparam int POS_W    = 24;
    localparam int ORBIT_W  = 32;

    localparam int PROD_W      = RATE_W + STEP_W;
    localparam int WHOLE_ADD_W = PROD_W - PHASE_FRACTION_BITS + 1;

    localparam int CORDIC_STEPS = 16;
    localparam int STEP_IDX_W   = $clog2(CORDIC_STEPS);
    localparam int CORDIC_W     = 32;
    localparam int Z_W          = 32;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 32'sd652032874;

    localparam int MUL_R_W     = RADIUS_W + 1 + CORDIC_W;
    localparam int ROUND_X_SH  = 30;
    localparam int ROUND_Y_SH  = 14;
    localparam int YP_W        = MUL_R_W - ROUND_Y_SH;
    localparam int MUL_T_W     = YP_W + INCL_W;
    localparam int TILT_SH     = 32;

    localparam logic signed [63:0] POS_MAX = 64'sd8388607;
    localparam logic signed [63:0] POS_MIN = -64'sd8388607;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PHASE_RATE = 3'd0,
        REG_MAX_STEP   = 3'd1,
        REG_RADIUS     = 3'd2,
        REG_COS_INCL   = 3'd3,
        REG_SIN_INCL   = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [RATE_W-1:0]          phase_rate;
        logic [STEP_W-1:0]          max_step_us;
        logic [RADIUS_W-1:0]        radius_m;
        logic signed [INCL_W-1:0]   cos_inclination;
        logic signed [INCL_W-1:0]   sin_inclination;
    } cop_cfg_t;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] angle;
        logic [ORBIT_W-1:0]    orbits;
        logic                  completed;
    } cop_item_t;

    // arctangent of 2^-i in 2^-32 turn
    function automatic logic signed [Z_W-1:0] atan_step(input logic [STEP_IDX_W-1:0] idx);
        logic signed [Z_W-1:0] a;
        case (idx)
            4'd0:    a = 32'sd536870912;
            4'd1:    a = 32'sd316933406;
            4'd2:    a = 32'sd167458907;
            4'd3:    a = 32'sd85004756;
            4'd4:    a = 32'sd42667331;
            4'd5:    a = 32'sd21354465;
            4'd6:    a = 32'sd10679838;
            4'd7:    a = 32'sd5340245;
            4'd8:    a = 32'sd2670163;
            4'd9:    a = 32'sd1335087;
            4'd10:   a = 32'sd667544;
            4'd11:   a = 32'sd333772;
            4'd12:   a = 32'sd166886;
            4'd13:   a = 32'sd83443;
            4'd14:   a = 32'sd41722;
            4'd15:   a = 32'sd20861;
            default: a = '0;
        endcase
        return a;
    endfunction

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [63:0] v);
        logic signed [63:0] r;
        if (v > POS_MAX)
        begin
            r = POS_MAX;
        end
        else if (v < POS_MIN)
        begin
            r = POS_MIN;
        end
        else
        begin
            r = v;
        end
        return r[POS_W-1:0];
    endfunction

endpackage

// ===== rtl/cop_front.sv =====
// Front end: takes ticks, forms the clamped step and advances the orbit phase.
module cop_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cop_pkg::cop_cfg_t             cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [cop_pkg::TIME_W-1:0]    now_us,
    output logic                          push_valid,
    input  logic                          push_ready,
    output cop_pkg::cop_item_t            push_item
);
    import cop_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_ACC
    } state_t;

    state_t                        state_reg;
    logic                          started_reg;
    logic [TIME_W-1:0]             last_time_reg;
    logic [PHASE_FRACTION_BITS-1:0] phase_reg;
    logic [PHASE_FRACTION_BITS-1:0] phase_next;
    logic [ORBIT_W-1:0]            orbits_reg;
    logic [ORBIT_W-1:0]            orbits_next;
    logic [STEP_W-1:0]             dt_reg;
    logic [STEP_W-1:0]             dt_next;
    logic [PROD_W-1:0]             inc_reg;
    logic [PROD_W-1:0]             prod;
    logic [TIME_W-1:0]             diff;
    logic [PHASE_FRACTION_BITS:0]  frac_sum;
    logic [WHOLE_ADD_W-1:0]        add_whole;
    logic                          accept;
    logic                          push;

    assign in_ready   = (state_reg == S_IDLE);
    assign accept     = in_valid && in_ready;
    assign push_valid = (state_reg == S_ACC);
    assign push       = push_valid && push_ready;

    // zero on first tick or when time steps back, clamped to max_step_us
    always_comb
    begin
        diff    = now_us - last_time_reg;
        dt_next = '0;
        if (started_reg && (now_us > last_time_reg))
        begin
            if (diff > TIME_W'(cfg.max_step_us))
            begin
                dt_next = cfg.max_step_us;
            end
            else
            begin
                dt_next = diff[STEP_W-1:0];
            end
        end
    end

    assign prod = dt_reg * cfg.phase_rate;

    always_comb
    begin
        frac_sum    = {1'b0, phase_reg} + {1'b0, inc_reg[PHASE_FRACTION_BITS-1:0]};
        add_whole   = WHOLE_ADD_W'(inc_reg[PROD_W-1:PHASE_FRACTION_BITS])
                    + WHOLE_ADD_W'(frac_sum[PHASE_FRACTION_BITS]);
        phase_next  = frac_sum[PHASE_FRACTION_BITS-1:0];
        orbits_next = orbits_reg + ORBIT_W'(add_whole);

        push_item.angle     = phase_next[PHASE_FRACTION_BITS-1 -: ANGLE_BITS];
        push_item.orbits    = orbits_next;
        push_item.completed = (add_whole != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            started_reg   <= 1'b0;
            last_time_reg <= '0;
            phase_reg     <= '0;
            orbits_reg    <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        started_reg   <= 1'b1;
                        last_time_reg <= now_us;
                        state_reg     <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    if (push)
                    begin
                        phase_reg  <= phase_next;
                        orbits_reg <= orbits_next;
                        state_reg  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dt_reg <= dt_next;
        end
        if (state_reg == S_MUL)
        begin
            inc_reg <= prod;
        end
    end

endmodule

// ===== rtl/cop_queue.sv =====
// Short queue between the phase front end and the position back end.
module cop_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  cop_pkg::cop_item_t   push_item,
    output logic                 pop_valid,
    input  logic                 pop,
    output cop_pkg::cop_item_t   pop_item
);
    import cop_pkg::*;

    cop_item_t               entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]  wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0]  rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0]  count_reg;
    logic                    do_push;
    logic                    do_pop;

    assign push_ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_item   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                if (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1))
                begin
                    wr_ptr_reg <= '0;
                end
                else
                begin
                    wr_ptr_reg <= wr_ptr_reg + 1'b1;
                end
            end
            if (do_pop)
            begin
                if (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1))
                begin
                    rd_ptr_reg <= '0;
                end
                else
                begin
                    rd_ptr_reg <= rd_ptr_reg + 1'b1;
                end
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/cop_back.sv =====
// Back end: iterative CORDIC, radius scaling, inclination tilt and result register.
module cop_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  cop_pkg::cop_cfg_t                   cfg,
    input  logic                                pop_valid,
    output logic                                pop,
    input  cop_pkg::cop_item_t                  pop_item,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [cop_pkg::POS_W-1:0]    pos_x_m,
    output logic signed [cop_pkg::POS_W-1:0]    pos_y_m,
    output logic signed [cop_pkg::POS_W-1:0]    pos_z_m,
    output logic [cop_pkg::ANGLE_BITS-1:0]      orbit_angle,
    output logic [cop_pkg::ORBIT_W-1:0]         orbits_done,
    output logic                                orbit_completed
);
    import cop_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROT,
        S_MAP,
        S_SCALE,
        S_ROUND,
        S_TILT,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        QUAD_I,
        QUAD_II,
        QUAD_III,
        QUAD_IV
    } quad_t;

    localparam logic signed [MUL_R_W-1:0] X_HALF = MUL_R_W'(1) << (ROUND_X_SH - 1);
    localparam logic signed [MUL_R_W-1:0] Y_HALF = MUL_R_W'(1) << (ROUND_Y_SH - 1);
    localparam logic signed [MUL_T_W-1:0] T_HALF = MUL_T_W'(1) << (TILT_SH - 1);

    state_t                       state_reg;
    logic [STEP_IDX_W-1:0]        step_reg;
    quad_t                        quad_reg;
    cop_item_t                    item_reg;
    logic signed [CORDIC_W-1:0]   x_reg;
    logic signed [CORDIC_W-1:0]   y_reg;
    logic signed [Z_W-1:0]        z_reg;
    logic signed [CORDIC_W-1:0]   x_next;
    logic signed [CORDIC_W-1:0]   y_next;
    logic signed [Z_W-1:0]        z_next;
    logic signed [CORDIC_W-1:0]   x_sh;
    logic signed [CORDIC_W-1:0]   y_sh;
    logic signed [Z_W-1:0]        atan;
    logic signed [CORDIC_W-1:0]   c_reg;
    logic signed [CORDIC_W-1:0]   s_reg;
    logic signed [CORDIC_W-1:0]   c_next;
    logic signed [CORDIC_W-1:0]   s_next;
    logic signed [RADIUS_W:0]     radius_s;
    logic signed [MUL_R_W-1:0]    pc_reg;
    logic signed [MUL_R_W-1:0]    ps_reg;
    logic signed [MUL_R_W-1:0]    xs;
    logic signed [MUL_R_W-1:0]    ys;
    logic signed [POS_W-1:0]      xm_reg;
    logic signed [YP_W-1:0]       yp_reg;
    logic signed [MUL_T_W-1:0]    py_reg;
    logic signed [MUL_T_W-1:0]    pz_reg;
    logic signed [MUL_T_W-1:0]    py_sh;
    logic signed [MUL_T_W-1:0]    pz_sh;
    logic                         load_out;

    assign pop      = (state_reg == S_IDLE) && pop_valid;
    assign load_out = (state_reg == S_OUT) && (!out_valid || out_ready);
    assign radius_s = signed'({1'b0, cfg.radius_m});

    // one rotation per cycle, shifts round toward minus infinity
    always_comb
    begin
        x_sh = x_reg >>> step_reg;
        y_sh = y_reg >>> step_reg;
        atan = atan_step(step_reg);
        if (!z_reg[Z_W-1])
        begin
            x_next = x_reg - y_sh;
            y_next = y_reg + x_sh;
            z_next = z_reg - atan;
        end
        else
        begin
            x_next = x_reg + y_sh;
            y_next = y_reg - x_sh;
            z_next = z_reg + atan;
        end
    end

    always_comb
    begin
        case (quad_reg)
            QUAD_I:
            begin
                c_next = x_reg;
                s_next = y_reg;
            end
            QUAD_II:
            begin
                c_next = -y_reg;
                s_next = x_reg;
            end
            QUAD_III:
            begin
                c_next = -x_reg;
                s_next = -y_reg;
            end
            default:
            begin
                c_next = y_reg;
                s_next = -x_reg;
            end
        endcase
    end

    always_comb
    begin
        xs    = (pc_reg + X_HALF) >>> ROUND_X_SH;
        ys    = (ps_reg + Y_HALF) >>> ROUND_Y_SH;
        py_sh = (py_reg + T_HALF) >>> TILT_SH;
        pz_sh = (pz_reg + T_HALF) >>> TILT_SH;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        step_reg  <= '0;
                        state_reg <= S_ROT;
                    end
                end
                S_ROT:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_IDX_W'(CORDIC_STEPS - 1))
                    begin
                        state_reg <= S_MAP;
                    end
                end
                S_MAP:
                begin
                    state_reg <= S_SCALE;
                end
                S_SCALE:
                begin
                    state_reg <= S_ROUND;
                end
                S_ROUND:
                begin
                    state_reg <= S_TILT;
                end
                S_TILT:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (load_out)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= pop_item;
            quad_reg <= quad_t'(pop_item.angle[ANGLE_BITS-1 -: 2]);
            x_reg    <= CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= Z_W'({pop_item.angle[ANGLE_BITS-3:0], {(Z_W - ANGLE_BITS){1'b0}}});
        end
        else if (state_reg == S_ROT)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
        if (state_reg == S_MAP)
        begin
            c_reg <= c_next;
            s_reg <= s_next;
        end
        if (state_reg == S_SCALE)
        begin
            pc_reg <= radius_s * c_reg;
            ps_reg <= radius_s * s_reg;
        end
        if (state_reg == S_ROUND)
        begin
            xm_reg <= sat_pos(64'(xs));
            yp_reg <= YP_W'(ys);
        end
        if (state_reg == S_TILT)
        begin
            py_reg <= yp_reg * cfg.cos_inclination;
            pz_reg <= yp_reg * cfg.sin_inclination;
        end
        if (load_out)
        begin
            pos_x_m         <= xm_reg;
            pos_y_m         <= sat_pos(64'(py_sh));
            pos_z_m         <= sat_pos(64'(pz_sh));
            orbit_angle     <= item_reg.angle;
            orbits_done     <= item_reg.orbits;
            orbit_completed <= item_reg.completed;
        end
    end

endmodule

// ===== rtl/circular_orbit_position_propagator_top.sv =====
// Circular orbit position propagator: configuration registers and block top level.
//
// Each tick transaction carries a microsecond timestamp and yields one position
// transaction. The front end clamps the step, does the 32x32 phase multiply and
// accumulates the phase, then hands the angle and orbit count to a two-entry
// queue; it takes no new tick until the queue has taken the last result. The
// back end runs the single-rotator CORDIC, then quadrant mapping, radius
// scaling, rounding, inclination tilt and the output register, and pops no new
// tick until its last result is in the output register. A finished position
// waits in the output register while the next tick is taken.
// Configuration writes take effect at once and are meant for an idle block.
module circular_orbit_position_propagator_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [cop_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cop_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [cop_pkg::TIME_W-1:0]          now_us,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [cop_pkg::POS_W-1:0]    pos_x_m,
    output logic signed [cop_pkg::POS_W-1:0]    pos_y_m,
    output logic signed [cop_pkg::POS_W-1:0]    pos_z_m,
    output logic [cop_pkg::ANGLE_BITS-1:0]      orbit_angle,
    output logic [cop_pkg::ORBIT_W-1:0]         orbits_done,
    output logic                                orbit_completed
);
    import cop_pkg::*;

    cop_cfg_t   cfg_reg;
    logic       q_push_valid;
    logic       q_push_ready;
    cop_item_t  q_push_item;
    logic       q_pop_valid;
    logic       q_pop;
    cop_item_t  q_pop_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_rate      <= 32'd595909;
            cfg_reg.max_step_us     <= 32'd1000000;
            cfg_reg.radius_m        <= 23'd6871000;
            cfg_reg.cos_inclination <= 18'sd40708;
            cfg_reg.sin_inclination <= 18'sd51360;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PHASE_RATE: cfg_reg.phase_rate      <= cfg_data[RATE_W-1:0];
                REG_MAX_STEP:   cfg_reg.max_step_us     <= cfg_data[STEP_W-1:0];
                REG_RADIUS:     cfg_reg.radius_m        <= cfg_data[RADIUS_W-1:0];
                REG_COS_INCL:   cfg_reg.cos_inclination <= signed'(cfg_data[INCL_W-1:0]);
                REG_SIN_INCL:   cfg_reg.sin_inclination <= signed'(cfg_data[INCL_W-1:0]);
                default:        ;
            endcase
        end
    end

    cop_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .now_us     (now_us),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_item  (q_push_item)
    );

    cop_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_item  (q_push_item),
        .pop_valid  (q_pop_valid),
        .pop        (q_pop),
        .pop_item   (q_pop_item)
    );

    cop_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .pop_valid       (q_pop_valid),
        .pop             (q_pop),
        .pop_item        (q_pop_item),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .pos_x_m         (pos_x_m),
        .pos_y_m         (pos_y_m),
        .pos_z_m         (pos_z_m),
        .orbit_angle     (orbit_angle),
        .orbits_done     (orbits_done),
        .orbit_completed (orbit_completed)
    );

    // a stalled phase update must not advance or change before the queue takes it
    a_push_hold: assert property (@(posedge clk) disable iff (!rst_n)
        q_push_valid && !q_push_ready |=> q_push_valid && $stable(q_push_item))
        else $error("phase transaction changed while stalled by the queue");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_pop_valid)
        else $error("back end popped an empty queue");

    // saturation is symmetric, the most negative code never appears
    a_pos_symmetric: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pos_x_m != 24'h800000) && (pos_y_m != 24'h800000)
                      && (pos_z_m != 24'h800000))
        else $error("position left the saturation range");

endmodule
